// ===== src/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] message_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        is_last;
    } out_item_t;

    localparam int CountWidth = 61;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LengthOffset = 6'd56;

    localparam logic [255:0] InitialHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== src/sha256_round.sv =====
`default_nettype none
module sha256_round (
    input  wire logic [255:0] state,
    input  wire logic [31:0]  w,
    input  wire logic [31:0]  k,
    output logic      [255:0] result
);
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = state;
        t1 = h + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
            + ((e & f) ^ (~e & g)) + k + w;
        t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
            + ((a & b) ^ (a & c) ^ (b & c));
        result = {t1 + t2, a, b, c, d + t1, e, f, g};
    end
endmodule
`default_nettype wire

// ===== src/sha256_byte_stream_hasher.sv =====
`default_nettype none
// A message byte is taken whenever the block is idle; a byte that completes a block
// then holds the input while the block is loaded, 64 rounds run and the sum is added.
// A finish item at block offset p pads the rest of the block and runs one compression;
// at offset 56 or more, a further block of padding and a second compression follow.
// Then the eight digest words are offered, one per cycle as the sink takes them.
// Reset (rst_n, asynchronous, active low) loads the initial hash and clears the count.
module sha256_byte_stream_hasher (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sha256_pkg::in_item_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output sha256_pkg::out_item_t      out_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]   state_reg;
    logic [60:0]  count_reg;
    logic [255:0] chain_reg;
    logic [255:0] work_reg;
    logic [511:0] win_reg;
    logic [6:0]   step_reg;
    logic [5:0]   pad_reg;
    logic         fin_reg;
    logic         second_reg;
    logic [63:0]  bits_reg;
    logic [2:0]   oidx_reg;

    logic [7:0] buffer_mem [64];
    logic [7:0] rd_reg;
    logic [5:0] rd_addr;
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;

    logic [31:0]  w_cur, w2, w15, w_new;
    logic [255:0] round_out;
    logic [5:0]   pos;

    assign pos = count_reg[5:0];
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT) && (step_reg != 7'd64);
    assign out_data.digest_word = chain_reg[255 - 32 * oidx_reg -: 32];
    assign out_data.is_last = (oidx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buffer_mem[wr_addr] <= wr_data;
        end
        rd_reg <= buffer_mem[rd_addr];
    end

    assign w2  = win_reg[14 * 32 +: 32];
    assign w15 = win_reg[1 * 32 +: 32];
    assign w_new = (sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10))
        + win_reg[9 * 32 +: 32]
        + (sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3))
        + win_reg[0 +: 32];
    assign w_cur = (step_reg < 7'd16) ? win_reg[0 +: 32] : w_new;

    sha256_round u_round (
        .state  (work_reg),
        .w      (w_cur),
        .k      (sha256_pkg::round_k(step_reg[5:0])),
        .result (round_out)
    );

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = pos;
        wr_data = in_data.message_byte;
        rd_addr = {step_reg[5:2], ~step_reg[1:0]};
        if (state_reg == S_IDLE && in_valid)
        begin
            wr_en = 1'b1;
            wr_data = in_data.operation ? sha256_pkg::PadByte : in_data.message_byte;
        end
        else if (state_reg == S_PAD)
        begin
            wr_en = 1'b1;
            wr_addr = pad_reg;
            if (second_reg && pad_reg < sha256_pkg::LengthOffset)
                wr_data = 8'h00;
            else if (!second_reg && pad_reg < sha256_pkg::LengthOffset)
                wr_data = 8'h00;
            else if (second_reg || pos < sha256_pkg::LengthOffset)
                wr_data = bits_reg[8 * (63 - pad_reg) +: 8];
            else
                wr_data = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            chain_reg <= sha256_pkg::InitialHash;
            step_reg <= '0;
            pad_reg <= '0;
            fin_reg <= 1'b0;
            second_reg <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        step_reg <= '0;
                        if (in_data.operation)
                        begin
                            fin_reg <= 1'b1;
                            second_reg <= 1'b0;
                            bits_reg <= {count_reg, 3'b000};
                            if (pos == 6'd63)
                                state_reg <= (count_reg[5:0] >= sha256_pkg::LengthOffset)
                                    ? S_LOAD : S_PAD;
                            else
                                state_reg <= S_PAD;
                            pad_reg <= pos + 6'd1;
                        end
                        else
                        begin
                            count_reg <= count_reg + 61'd1;
                            fin_reg <= 1'b0;
                            if (pos == 6'd63)
                                state_reg <= S_LOAD;
                        end
                    end
                end
                S_PAD:
                begin
                    pad_reg <= pad_reg + 6'd1;
                    if (pad_reg == 6'd63)
                    begin
                        step_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // Byte address step_reg, low two bits inverted, is read; data arrives in rd_reg in the next cycle.
                    if (step_reg != 7'd0)
                        win_reg <= {rd_reg, win_reg[511:8]};
                    if (step_reg == 7'd64)
                    begin
                        step_reg <= '0;
                        work_reg <= chain_reg;
                        state_reg <= S_RND;
                    end
                    else
                        step_reg <= step_reg + 7'd1;
                end
                S_RND:
                begin
                    work_reg <= round_out;
                    win_reg <= {w_cur, win_reg[511:32]};
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd63)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (oidx_reg == 3'd0 && step_reg == 7'd64)
                    begin
                        step_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            chain_reg[32 * i +: 32] <= chain_reg[32 * i +: 32]
                                + work_reg[32 * i +: 32];
                        if (!fin_reg)
                            state_reg <= S_IDLE;
                        else if (!second_reg && pos >= sha256_pkg::LengthOffset)
                        begin
                            second_reg <= 1'b1;
                            pad_reg <= '0;
                            state_reg <= S_PAD;
                        end
                    end
                    else if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            chain_reg <= sha256_pkg::InitialHash;
                            count_reg <= '0;
                            fin_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== test/sha256_byte_stream_hasher_tb.sv =====
`default_nettype none
module sha256_byte_stream_hasher_tb;

    localparam logic OpAbsorb = 1'b0;
    localparam logic OpFinish = 1'b1;
    localparam int CycleLimit = 2000000;

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic clk;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    sha256_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sha256_pkg::out_item_t out_data;

    sha256_byte_stream_hasher DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    logic [31:0] hash_state [8];
    logic [7:0] msg_block [64];
    logic [60:0] msg_length;
    sha256_pkg::out_item_t digest_queue [$];
    sha256_pkg::in_item_t pending_items [$];

    int errors = 0;
    int cycles = 0;
    bit quiet_phase = 0;
    bit hold_sender = 0;
    bit hold_request = 0;
    bit hold_done = 0;
    bit in_taken = 0;
    int long_hold = 0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = sha256_pkg::InitialHash[255 - 32 * i -: 32];
        end
        msg_length = '0;
    endfunction

    function automatic void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4 * i], msg_block[4 * i + 1], msg_block[4 * i + 2],
                    msg_block[4 * i + 3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = (ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10)) + w[i - 7]
                 + (ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3)) + w[i - 16];
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_state[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] += v[i];
        end
    endfunction

    function automatic void predict_digest(sha256_pkg::in_item_t item);
        int pos;
        logic [63:0] bits;
        sha256_pkg::out_item_t word;
        pos = int'(msg_length[5:0]);
        if (item.operation == OpAbsorb)
        begin
            msg_block[pos] = item.message_byte;
            msg_length = msg_length + 61'd1;
            if (pos == 63)
            begin
                compress();
            end
        end
        else
        begin
            bits = {msg_length, 3'b000};
            msg_block[pos] = sha256_pkg::PadByte;
            for (int i = pos + 1; i < 64; i++)
            begin
                msg_block[i] = 8'h00;
            end
            if (pos >= int'(sha256_pkg::LengthOffset))
            begin
                compress();
                for (int i = 0; i < 56; i++)
                begin
                    msg_block[i] = 8'h00;
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                msg_block[63 - i] = bits[8 * i +: 8];
            end
            compress();
            for (int i = 0; i < 8; i++)
            begin
                word.digest_word = hash_state[i];
                word.is_last = (i == 7);
                digest_queue.push_back(word);
            end
            restart_hash();
        end
    endfunction

    function automatic void add_message(int len, int fill);
        sha256_pkg::in_item_t item;
        for (int i = 0; i < len; i++)
        begin
            item.operation = OpAbsorb;
            case (fill)
                0: item.message_byte = 8'h00;
                1: item.message_byte = 8'hff;
                default: item.message_byte = 8'($urandom_range(0, 255));
            endcase
            pending_items.push_back(item);
        end
        item.operation = OpFinish;
        item.message_byte = 8'($urandom_range(0, 255));
        pending_items.push_back(item);
    endfunction

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && !hold_sender)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(1, 13);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done <= 1'b1;
            long_hold <= 400;
            out_ready <= 1'b0;
        end
        else if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                recv_gap <= $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk)
    begin
        sha256_pkg::out_item_t want;
        if (rst_n && in_valid && in_ready)
        begin
            predict_digest(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("digest word with none expected: %h", out_data.digest_word);
                errors++;
            end
            else
            begin
                want = digest_queue.pop_front();
                if (out_data.digest_word !== want.digest_word)
                begin
                    $error("digest_word expected %h actual %h", want.digest_word,
                           out_data.digest_word);
                    errors++;
                end
                if (out_data.is_last !== want.is_last)
                begin
                    $error("is_last expected %b actual %b", want.is_last, out_data.is_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int len;
        int budget;
        rst_n = 0;
        restart_hash();
        add_message(0, 2);
        add_message(3, 2);
        add_message(1, 0);
        add_message(1, 1);
        add_message(0, 2);
        repeat (9) @(posedge clk);
        rst_n <= 1;
        wait (pending_items.size() == 0 && !in_valid);
        add_message(55, 2);
        add_message(56, 1);
        add_message(63, 2);
        add_message(64, 0);
        hold_request = 1;
        wait (pending_items.size() == 0 && !in_valid);
        hold_sender = 1;
        wait (digest_queue.size() == 0);
        hold_sender = 0;
        budget = 80;
        while (budget > 0)
        begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                default: len = $urandom_range(0, 40);
            endcase
            add_message(len, 2);
            budget -= len + 1;
            if (budget < 30)
            begin
                quiet_phase = 1;
            end
            wait (pending_items.size() < 20);
        end
        quiet_phase = 1;
        wait (pending_items.size() == 0 && !in_valid);
        wait (digest_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
